// ===== rtl/rtlpm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rtlpm_pkg;

   localparam int ROUTE_DEPTH_DEF = 64;
   localparam int IFACE_COUNT_DEF = 16;
   // interface index field is four bits wide
   localparam int IFACE_SLOTS     = 16;

   localparam logic [2:0] CMD_ADD_IFACE = 3'd0;
   localparam logic [2:0] CMD_ADD_ROUTE = 3'd1;
   localparam logic [2:0] CMD_SET_ADMIN = 3'd2;
   localparam logic [2:0] CMD_SET_OPER  = 3'd3;
   localparam logic [2:0] CMD_LOOKUP    = 3'd4;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_DUP     = 3'd1;
   localparam logic [2:0] ST_NOHOP   = 3'd2;
   localparam logic [2:0] ST_UNRES   = 3'd3;
   localparam logic [2:0] ST_UNKNOWN = 3'd4;
   localparam logic [2:0] ST_FULL    = 3'd5;
   localparam logic [2:0] ST_NOROUTE = 3'd6;

   localparam logic [5:0] MAX_LEN = 6'd32;

   typedef enum logic {
      FSM_IDLE,
      FSM_SCAN
   } fsm_type;

   typedef struct packed {
      logic [31:0] prefix;
      logic [5:0]  len;
      logic        has_nh;
      logic [31:0] nh;
      logic [3:0]  egress;
      logic [7:0]  pref;
      logic        connected;
   } route_type;

   // search word handed from cell to cell
   typedef struct packed {
      logic        active;
      logic        resolve;
      logic [31:0] addr;
      logic        hit;
      route_type   best;
   } token_type;

   function automatic logic [31:0] len_mask(input logic [5:0] len);
      logic [31:0] m;
      if (len == 6'd0) begin
         m = 32'd0;
      end else begin
         m = 32'hFFFF_FFFF << (MAX_LEN - len);
      end
      return m;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/rtlpm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface rtlpm_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic [3:0]  iface_index;
   logic [31:0] address;
   logic [5:0]  prefix_length;
   logic        has_next_hop;
   logic [31:0] hop_addr;
   logic        has_egress;
   logic [3:0]  egress_index;
   logic [7:0]  preference;
   logic        up_flag;

   modport source (output valid, command, iface_index, address, prefix_length,
                   has_next_hop, hop_addr, has_egress, egress_index, preference,
                   up_flag, input ready);
   modport sink (input valid, command, iface_index, address, prefix_length,
                 has_next_hop, hop_addr, has_egress, egress_index, preference,
                 up_flag, output ready);
endinterface

interface rtlpm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] route_prefix;
   logic [5:0]  route_prefix_length;
   logic        route_has_next_hop;
   logic [31:0] route_next_hop;
   logic [3:0]  route_egress;
   logic [7:0]  route_preference;
   logic        route_connected;
   logic [6:0]  route_total;

   modport source (output valid, status, route_prefix, route_prefix_length,
                   route_has_next_hop, route_next_hop, route_egress,
                   route_preference, route_connected, route_total, input ready);
   modport sink (input valid, status, route_prefix, route_prefix_length,
                 route_has_next_hop, route_next_hop, route_egress,
                 route_preference, route_connected, route_total, output ready);
endinterface
`default_nettype wire

// ===== rtl/route_table_lpm_lookup.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Route table with longest-prefix-match lookup. Interface commands and set
// admin/oper are answered straight from the request; a lookup, and an add
// route whose egress must be resolved from its next hop, send a search word
// down a row of ROUTE_DEPTH cells (one cell per route slot), and the result
// is made from the word that leaves the last cell. One item is worked at a
// time; the result word sits in an output register until it is taken.
module route_table_lpm_lookup #(
   parameter int ROUTE_DEPTH = rtlpm_pkg::ROUTE_DEPTH_DEF,
   parameter int IFACE_COUNT = rtlpm_pkg::IFACE_COUNT_DEF
) (
   input  wire        clock,
   input  wire        reset,
   rtlpm_req_if.sink   req_ch,
   rtlpm_rsp_if.source rsp_ch
);
   import rtlpm_pkg::*;

   localparam int IW = $clog2(ROUTE_DEPTH);
   localparam int FW = $clog2(ROUTE_DEPTH + 1);

   fsm_type                 state_ff, state_in;
   logic [FW-1:0]           fill_ff, fill_in;
   logic [IFACE_SLOTS-1:0]  present_ff, present_in;
   logic [IFACE_SLOTS-1:0]  admin_ff, admin_in;
   logic [IFACE_SLOTS-1:0]  oper_ff, oper_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [2:0]              status_ff, status_in;
   route_type               rsp_route_ff, rsp_route_in;
   logic [6:0]              total_ff, total_in;

   // held request fields while the chain runs
   logic [31:0]             h_addr_ff;
   logic [5:0]              h_len_ff;
   logic                    h_hnh_ff;
   logic [31:0]             h_nh_ff;
   logic [7:0]              h_pref_ff;

   logic                    accept;
   logic                    full;
   logic [5:0]              len_sat;
   logic                    idx_ok;
   logic                    eg_ok;
   logic                    wr_en;
   route_type               wr_route;
   token_type               tok_start;
   token_type               tok_end;

   assign accept = req_ch.valid && req_ch.ready;
   assign full   = fill_ff >= FW'(ROUTE_DEPTH);
   assign len_sat = (req_ch.prefix_length > MAX_LEN) ? MAX_LEN : req_ch.prefix_length;
   assign idx_ok = {28'd0, req_ch.iface_index} < IFACE_COUNT;
   assign eg_ok  = {28'd0, req_ch.egress_index} < IFACE_COUNT &&
                   present_ff[req_ch.egress_index];

   assign req_ch.ready = (state_ff == FSM_IDLE) && (!rsp_valid_ff || rsp_ch.ready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (accept && (req_ch.command == CMD_LOOKUP ||
                (req_ch.command == CMD_ADD_ROUTE && !req_ch.has_egress &&
                 req_ch.has_next_hop))) begin
               state_in = FSM_SCAN;
            end
         end
         FSM_SCAN: begin
            if (tok_end.active) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // command decode, table updates and result word
   always_comb begin
      fill_in      = fill_ff;
      present_in   = present_ff;
      admin_in     = admin_ff;
      oper_in      = oper_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      status_in    = status_ff;
      rsp_route_in = rsp_route_ff;
      total_in     = total_ff;
      wr_en        = 1'b0;
      wr_route     = '0;
      tok_start    = '0;
      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               status_in    = ST_OK;
               rsp_route_in = '0;
               case (req_ch.command)
                  CMD_ADD_IFACE: begin
                     if (!idx_ok) begin
                        status_in = ST_UNKNOWN;
                     end else if (present_ff[req_ch.iface_index]) begin
                        status_in = ST_DUP;
                     end else if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        present_in[req_ch.iface_index] = 1'b1;
                        admin_in[req_ch.iface_index]   = req_ch.up_flag;
                        oper_in[req_ch.iface_index]    = req_ch.up_flag;
                        wr_en              = 1'b1;
                        wr_route.prefix    = req_ch.address & len_mask(len_sat);
                        wr_route.len       = len_sat;
                        wr_route.egress    = req_ch.iface_index;
                        wr_route.connected = 1'b1;
                        fill_in            = fill_ff + FW'(1);
                     end
                  end
                  CMD_ADD_ROUTE: begin
                     if (!req_ch.has_next_hop && !req_ch.has_egress) begin
                        status_in = ST_NOHOP;
                     end else if (!req_ch.has_egress) begin
                        tok_start.active  = 1'b1;
                        tok_start.resolve = 1'b1;
                        tok_start.addr    = req_ch.hop_addr;
                     end else if (!eg_ok) begin
                        status_in = ST_UNKNOWN;
                     end else if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en           = 1'b1;
                        wr_route.prefix = req_ch.address & len_mask(len_sat);
                        wr_route.len    = len_sat;
                        wr_route.has_nh = req_ch.has_next_hop;
                        wr_route.nh     = req_ch.has_next_hop ? req_ch.hop_addr : 32'd0;
                        wr_route.egress = req_ch.egress_index;
                        wr_route.pref   = req_ch.preference;
                        fill_in         = fill_ff + FW'(1);
                     end
                  end
                  CMD_SET_ADMIN, CMD_SET_OPER: begin
                     if (!idx_ok || !present_ff[req_ch.iface_index]) begin
                        status_in = ST_UNKNOWN;
                     end else if (req_ch.command == CMD_SET_ADMIN) begin
                        admin_in[req_ch.iface_index] = req_ch.up_flag;
                     end else begin
                        oper_in[req_ch.iface_index] = req_ch.up_flag;
                     end
                  end
                  CMD_LOOKUP: begin
                     tok_start.active = 1'b1;
                     tok_start.addr   = req_ch.address;
                  end
                  default: status_in = ST_OK;
               endcase
               total_in     = 7'(fill_in);
               rsp_valid_in = !tok_start.active;
            end
         end
         FSM_SCAN: begin
            if (tok_end.active) begin
               status_in    = ST_OK;
               rsp_route_in = '0;
               if (tok_end.resolve) begin
                  if (!tok_end.hit) begin
                     status_in = ST_UNRES;
                  end else if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     wr_en           = 1'b1;
                     wr_route.prefix = h_addr_ff & len_mask(h_len_ff);
                     wr_route.len    = h_len_ff;
                     wr_route.has_nh = h_hnh_ff;
                     wr_route.nh     = h_nh_ff;
                     wr_route.egress = tok_end.best.egress;
                     wr_route.pref   = h_pref_ff;
                     fill_in         = fill_ff + FW'(1);
                  end
               end else if (!tok_end.hit) begin
                  status_in = ST_NOROUTE;
               end else begin
                  rsp_route_in = tok_end.best;
               end
               total_in     = 7'(fill_in);
               rsp_valid_in = 1'b1;
            end
         end
         default: rsp_valid_in = 1'b0;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         fill_ff      <= '0;
         present_ff   <= '0;
         admin_ff     <= '0;
         oper_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         present_ff   <= present_in;
         admin_ff     <= admin_in;
         oper_ff      <= oper_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      rsp_route_ff <= rsp_route_in;
      total_ff     <= total_in;
      if (accept) begin
         h_addr_ff <= req_ch.address;
         h_len_ff  <= len_sat;
         h_hnh_ff  <= req_ch.has_next_hop;
         h_nh_ff   <= req_ch.hop_addr;
         h_pref_ff <= req_ch.preference;
      end
   end

   rtlpm_chain #(
      .ROUTE_DEPTH (ROUTE_DEPTH)
   ) u_chain (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_idx   (fill_ff[IW-1:0]),
      .wr_route (wr_route),
      .fill     (fill_ff),
      .usable   (present_ff & admin_ff & oper_ff),
      .tok_in   (tok_start),
      .tok_out  (tok_end)
   );

   assign rsp_ch.valid               = rsp_valid_ff;
   assign rsp_ch.status              = status_ff;
   assign rsp_ch.route_prefix        = rsp_route_ff.prefix;
   assign rsp_ch.route_prefix_length = rsp_route_ff.len;
   assign rsp_ch.route_has_next_hop  = rsp_route_ff.has_nh;
   assign rsp_ch.route_next_hop      = rsp_route_ff.nh;
   assign rsp_ch.route_egress        = rsp_route_ff.egress;
   assign rsp_ch.route_preference    = rsp_route_ff.pref;
   assign rsp_ch.route_connected     = rsp_route_ff.connected;
   assign rsp_ch.route_total         = total_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(ROUTE_DEPTH))
      else $error("route fill beyond table depth");

   a_no_accept_in_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == FSM_SCAN |-> !req_ch.ready)
      else $error("request taken during chain search");

   a_end_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok_end.active |-> state_ff == FSM_SCAN)
      else $error("search word left chain outside scan");

   a_scan_leaves_result: assert property (@(posedge clock) disable iff (reset)
      tok_end.active |=> rsp_valid_ff && state_ff == FSM_IDLE)
      else $error("finished search produced no result word");

endmodule
`default_nettype wire

// ===== rtl/rtlpm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rtlpm_cell #(
   parameter int ROUTE_DEPTH = rtlpm_pkg::ROUTE_DEPTH_DEF,
   parameter int CELL_INDEX  = 0
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     wr_en,
   input  wire  [$clog2(ROUTE_DEPTH)-1:0]          wr_idx,
   input  wire  rtlpm_pkg::route_type              wr_route,
   input  wire  [$clog2(ROUTE_DEPTH+1)-1:0]        fill,
   input  wire  [rtlpm_pkg::IFACE_SLOTS-1:0]       usable,
   input  wire  rtlpm_pkg::token_type              tok_in,
   output rtlpm_pkg::token_type                    tok_out
);
   import rtlpm_pkg::*;

   localparam int IW = $clog2(ROUTE_DEPTH);
   localparam int FW = $clog2(ROUTE_DEPTH + 1);

   route_type entry_ff;
   token_type tok_ff;
   token_type tok_in_w;
   logic      live;
   logic      match;
   logic      eligible;
   logic      better;

   // store the route written to this slot
   always_ff @(posedge clock) begin
      if (wr_en && wr_idx == IW'(CELL_INDEX)) begin
         entry_ff <= wr_route;
      end
   end

   // compare held route against the passing word
   always_comb begin
      live     = FW'(CELL_INDEX) < fill;
      match    = (tok_in.addr & len_mask(entry_ff.len)) == entry_ff.prefix;
      eligible = live && match &&
                 (tok_in.resolve ? entry_ff.connected : usable[entry_ff.egress]);
      better   = !tok_in.hit || entry_ff.len > tok_in.best.len ||
                 (entry_ff.len == tok_in.best.len && entry_ff.pref < tok_in.best.pref);
      tok_in_w = tok_in;
      if (eligible && better) begin
         tok_in_w.hit  = 1'b1;
         tok_in_w.best = entry_ff;
      end
   end

   // advance the word to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.active <= 1'b0;
      end else begin
         tok_ff.active <= tok_in.active;
      end
      tok_ff.resolve <= tok_in_w.resolve;
      tok_ff.addr    <= tok_in_w.addr;
      tok_ff.hit     <= tok_in_w.hit;
      tok_ff.best    <= tok_in_w.best;
   end

   assign tok_out = tok_ff;

endmodule
`default_nettype wire

// ===== rtl/rtlpm_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rtlpm_chain #(
   parameter int ROUTE_DEPTH = rtlpm_pkg::ROUTE_DEPTH_DEF
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     wr_en,
   input  wire  [$clog2(ROUTE_DEPTH)-1:0]          wr_idx,
   input  wire  rtlpm_pkg::route_type              wr_route,
   input  wire  [$clog2(ROUTE_DEPTH+1)-1:0]        fill,
   input  wire  [rtlpm_pkg::IFACE_SLOTS-1:0]       usable,
   input  wire  rtlpm_pkg::token_type              tok_in,
   output rtlpm_pkg::token_type                    tok_out
);
   import rtlpm_pkg::*;

   token_type tok [ROUTE_DEPTH+1];

   assign tok[0] = tok_in;

   // one cell per route slot, in insertion order
   for (genvar i = 0; i < ROUTE_DEPTH; i++) begin : g_cell
      rtlpm_cell #(
         .ROUTE_DEPTH (ROUTE_DEPTH),
         .CELL_INDEX  (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .wr_en    (wr_en),
         .wr_idx   (wr_idx),
         .wr_route (wr_route),
         .fill     (fill),
         .usable   (usable),
         .tok_in   (tok[i]),
         .tok_out  (tok[i+1])
      );
   end

   assign tok_out = tok[ROUTE_DEPTH];

endmodule
`default_nettype wire

// ===== sim/route_table_lpm_lookup_tb_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces come with the RTL (rtl/rtlpm_if.sv); this file holds the
// response word type the scoreboard keeps for each accepted request.
package rtlpm_tb_pkg;
   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] prefix;
      logic [5:0]  prefix_length;
      logic        has_next_hop;
      logic [31:0] next_hop;
      logic [3:0]  egress;
      logic [7:0]  preference;
      logic        connected;
      logic [6:0]  total;
   } lpm_rsp_type;
endpackage

// ===== sim/route_table_lpm_lookup_tb.sv =====
`timescale 1ns / 1ps
module route_table_lpm_lookup_tb;
   import rtlpm_pkg::*;
   import rtlpm_tb_pkg::*;

   localparam int DEPTH = 64;
   localparam int NIF   = 16;

   // Route table predictor and store of expected response words
   class lpm_scoreboard;
      logic [31:0] tbl_prefix [DEPTH];
      logic [5:0]  tbl_len [DEPTH];
      logic        tbl_hnh [DEPTH];
      logic [31:0] tbl_nh [DEPTH];
      logic [3:0]  tbl_eg [DEPTH];
      logic [7:0]  tbl_pref [DEPTH];
      logic        tbl_conn [DEPTH];
      int          fill;
      bit          present [NIF];
      bit          admin [NIF];
      bit          oper [NIF];
      lpm_rsp_type pending [$];
      int          errors;

      function new();
         fill = 0;
         errors = 0;
         foreach (present[i]) begin
            present[i] = 0;
            admin[i] = 0;
            oper[i] = 0;
         end
      endfunction

      function logic [31:0] mask_of(logic [5:0] len);
         return (len == 0) ? 32'd0 : (32'hFFFF_FFFF << (6'd32 - len));
      endfunction

      function void append(logic [31:0] a, logic [5:0] len, logic hnh, logic [31:0] nh,
                           logic [3:0] eg, logic [7:0] pref, logic conn);
         tbl_prefix[fill] = a & mask_of(len);
         tbl_len[fill] = len;
         tbl_hnh[fill] = hnh;
         tbl_nh[fill] = nh;
         tbl_eg[fill] = eg;
         tbl_pref[fill] = pref;
         tbl_conn[fill] = conn;
         fill++;
      endfunction

      // longest connected route covering the hop, earlier wins on a tie
      function int resolve_egress(logic [31:0] hop);
         int best_eg;
         int longest;
         best_eg = -1;
         longest = -1;
         for (int i = 0; i < fill; i++) begin
            if (tbl_conn[i] && (hop & mask_of(tbl_len[i])) == tbl_prefix[i] &&
                int'(tbl_len[i]) > longest) begin
               longest = tbl_len[i];
               best_eg = tbl_eg[i];
            end
         end
         return best_eg;
      endfunction

      function void note_request(logic [2:0] cmd, logic [3:0] idx, logic [31:0] addr,
                                 logic [5:0] len_in, logic hnh, logic [31:0] nh,
                                 logic heg, logic [3:0] eg, logic [7:0] pref, logic up);
         lpm_rsp_type r;
         logic [5:0] len;
         int e;
         int best;
         r = '0;
         len = (len_in > 6'd32) ? 6'd32 : len_in;
         case (cmd)
            CMD_ADD_IFACE: begin
               if (present[idx]) r.status = ST_DUP;
               else if (fill >= DEPTH) r.status = ST_FULL;
               else begin
                  present[idx] = 1;
                  admin[idx] = up;
                  oper[idx] = up;
                  append(addr, len, 0, 0, idx, 0, 1);
               end
            end
            CMD_ADD_ROUTE: begin
               if (!hnh && !heg) r.status = ST_NOHOP;
               else begin
                  if (heg) e = present[eg] ? int'(eg) : -2;
                  else e = resolve_egress(nh);
                  if (e == -2) r.status = ST_UNKNOWN;
                  else if (e < 0) r.status = ST_UNRES;
                  else if (fill >= DEPTH) r.status = ST_FULL;
                  else append(addr, len, hnh, hnh ? nh : 32'd0, e[3:0], pref, 0);
               end
            end
            CMD_SET_ADMIN, CMD_SET_OPER: begin
               if (!present[idx]) r.status = ST_UNKNOWN;
               else if (cmd == CMD_SET_ADMIN) admin[idx] = up;
               else oper[idx] = up;
            end
            CMD_LOOKUP: begin
               best = -1;
               for (int i = 0; i < fill; i++) begin
                  if ((addr & mask_of(tbl_len[i])) != tbl_prefix[i]) continue;
                  if (!(present[tbl_eg[i]] && admin[tbl_eg[i]] && oper[tbl_eg[i]])) continue;
                  if (best < 0 || tbl_len[i] > tbl_len[best] ||
                      (tbl_len[i] == tbl_len[best] && tbl_pref[i] < tbl_pref[best]))
                     best = i;
               end
               if (best < 0) r.status = ST_NOROUTE;
               else begin
                  r.prefix = tbl_prefix[best];
                  r.prefix_length = tbl_len[best];
                  r.has_next_hop = tbl_hnh[best];
                  r.next_hop = tbl_nh[best];
                  r.egress = tbl_eg[best];
                  r.preference = tbl_pref[best];
                  r.connected = tbl_conn[best];
               end
            end
            default: ;
         endcase
         r.total = fill[6:0];
         pending = {pending, r};
      endfunction

      function void check_response(lpm_rsp_type got);
         lpm_rsp_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response word %h", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected %h got %h", want, got);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   rtlpm_req_if req_ch ();
   rtlpm_rsp_if rsp_ch ();
   lpm_scoreboard sb;
   int send_idle;
   int recv_stall;

   route_table_lpm_lookup dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("route_table_lpm_lookup_tb: errors");
      $finish;
   end

   // sample results at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_response({rsp_ch.status, rsp_ch.route_prefix,
                            rsp_ch.route_prefix_length, rsp_ch.route_has_next_hop,
                            rsp_ch.route_next_hop, rsp_ch.route_egress,
                            rsp_ch.route_preference, rsp_ch.route_connected,
                            rsp_ch.route_total});
   end

   // random receiver stall, updated on the falling edge
   always @(negedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= recv_stall);
   end

   task automatic send_word(logic [2:0] cmd, logic [3:0] idx, logic [31:0] addr,
                            logic [5:0] len, logic hnh, logic [31:0] nh, logic heg,
                            logic [3:0] eg, logic [7:0] pref, logic up);
      // drop valid only while idling, so back-to-back words keep it high
      while ($urandom_range(99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.command <= cmd;
      req_ch.iface_index <= idx;
      req_ch.address <= addr;
      req_ch.prefix_length <= len;
      req_ch.has_next_hop <= hnh;
      req_ch.hop_addr <= nh;
      req_ch.has_egress <= heg;
      req_ch.egress_index <= eg;
      req_ch.preference <= pref;
      req_ch.up_flag <= up;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_request(cmd, idx, addr, len, hnh, nh, heg, eg, pref, up);
      @(negedge clock);
   endtask

   // mostly well-formed traffic from a small address pool so lookups hit
   task automatic send_random();
      logic [31:0] base;
      logic [2:0] cmd;
      int pick;
      base = {8'd10, 8'($urandom_range(3)), 16'($urandom)};
      if ($urandom_range(9) == 0) base = $urandom;
      pick = $urandom_range(99);
      if (pick < 8) cmd = CMD_ADD_IFACE;
      else if (pick < 35) cmd = CMD_ADD_ROUTE;
      else if (pick < 45) cmd = CMD_SET_ADMIN;
      else if (pick < 55) cmd = CMD_SET_OPER;
      else if (pick < 97) cmd = CMD_LOOKUP;
      else cmd = 3'($urandom_range(7, 5));
      send_word(cmd, 4'($urandom), base, 6'($urandom_range(pick < 2 ? 63 : 32)),
                1'($urandom), {8'd10, 8'($urandom_range(3)), 16'($urandom)},
                1'($urandom), 4'($urandom), 8'($urandom), ($urandom_range(9) < 8));
   endtask

   initial begin
      sb = new();
      send_idle = 0;
      recv_stall = 0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.command = CMD_LOOKUP;
      req_ch.iface_index = '0;
      req_ch.address = '0;
      req_ch.prefix_length = '0;
      req_ch.has_next_hop = 1'b0;
      req_ch.hop_addr = '0;
      req_ch.has_egress = 1'b0;
      req_ch.egress_index = '0;
      req_ch.preference = '0;
      req_ch.up_flag = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, every status but ST_FULL, extremes, saturation
      send_word(CMD_LOOKUP, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
      send_word(CMD_SET_ADMIN, 15, 0, 0, 0, 0, 0, 0, 0, 1);
      send_word(CMD_ADD_ROUTE, 0, 32'h0A00_0000, 8, 1, 32'h0A00_0001, 0, 0, 0, 0);
      send_word(CMD_ADD_IFACE, 0, 32'h0A00_0001, 8, 0, 0, 0, 0, 0, 1);
      send_word(CMD_ADD_IFACE, 0, 32'h0B00_0001, 8, 0, 0, 0, 0, 0, 1);
      send_word(CMD_ADD_IFACE, 15, 32'hFFFF_FFFF, 63, 0, 0, 0, 0, 0, 1);
      send_word(CMD_ADD_IFACE, 7, 32'h0A01_0001, 16, 0, 0, 0, 0, 0, 0);
      send_word(CMD_ADD_ROUTE, 0, 32'h1400_0000, 8, 0, 0, 0, 0, 9, 0);
      send_word(CMD_ADD_ROUTE, 0, 32'h1400_0000, 8, 0, 0, 1, 9, 9, 0);
      send_word(CMD_ADD_ROUTE, 0, 32'h1400_0000, 8, 1, 32'h0C00_0001, 0, 0, 9, 0);
      send_word(CMD_ADD_ROUTE, 0, 32'h14FF_FFFF, 8, 1, 32'h0A01_0005, 0, 0, 200, 0);
      send_word(CMD_ADD_ROUTE, 0, 32'h1400_0000, 8, 1, 32'hFFFF_FFFF, 1, 0, 255, 0);
      send_word(CMD_ADD_ROUTE, 0, 32'h1400_0000, 8, 0, 32'h1234_5678, 1, 15, 0, 0);
      send_word(CMD_ADD_ROUTE, 0, 32'h0, 0, 1, 32'h0A00_0009, 0, 0, 255, 0);
      send_word(CMD_LOOKUP, 0, 32'h1400_0001, 0, 0, 0, 0, 0, 0, 0);
      send_word(CMD_SET_OPER, 7, 0, 0, 0, 0, 0, 0, 0, 1);
      send_word(CMD_SET_ADMIN, 7, 0, 0, 0, 0, 0, 0, 0, 1);
      send_word(CMD_LOOKUP, 0, 32'h1400_0001, 0, 0, 0, 0, 0, 0, 0);
      send_word(CMD_LOOKUP, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
      send_word(CMD_SET_OPER, 15, 0, 0, 0, 0, 0, 0, 0, 0);
      send_word(CMD_LOOKUP, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
      send_word(3'd7, 0, 32'hFFFF_FFFF, 6'h3F, 1, 32'hFFFF_FFFF, 1, 15, 255, 1);
      send_word(3'd5, 15, 0, 0, 0, 0, 0, 0, 0, 0);

      // random phases; fill the table to full along the way
      for (int ph = 0; ph < 4; ph++) begin
         send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 84 : 37) : 0;
         recv_stall = (ph == 2) ? 84 : (ph == 3 ? 37 : 0);
         for (int n = 0; n < 100; n++) send_random();
      end
      for (int n = 0; n < 70; n++)
         send_word(CMD_ADD_ROUTE, 0, $urandom, 6'($urandom_range(32)), 1'($urandom),
                   $urandom, 1, 0, 8'($urandom), 0);
      send_word(CMD_ADD_IFACE, 3, 32'h0A03_0000, 16, 0, 0, 0, 0, 0, 1);
      for (int n = 0; n < 10; n++) send_random();
      req_ch.valid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0)
         $display("route_table_lpm_lookup_tb: clean");
      else
         $display("route_table_lpm_lookup_tb: errors");
      $finish;
   end
endmodule
